// ===== rtl/core/pwli_pkg.sv =====
// Shared widths, defaults, operation codes and sequencer state codes for the table interpolator.
package pwli_pkg;

    // Field widths fixed by the interface.
    localparam int TIME_W = 32;
    localparam int VAL_W = 32;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    // Default table depth.
    localparam int MAX_POINTS_DEF = 64;

    // Divider step count: the quotient always fits in one time word.
    localparam int DIV_STEPS = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Reset value of the active point count.
    localparam logic [CNT_W-1:0] POINTS_RESET = CNT_W'(2);

    // Input item operations.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FIRST = 8'b0000_0010,
        S_LAST  = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_ADD   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

endpackage

// ===== rtl/core/piecewise_linear_table_interp.sv =====
// Piecewise-linear breakpoint table with a sequential interpolation engine.
//
// Input channel (in_valid / in_stall): op 0 writes one breakpoint into slot
// entry_index and gives no result; op 1 queries the value at query_time.
// A transfer happens at a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): one result per query, held in an
// output register until the receiver takes it with out_stall low.
// Configuration channel (cfg_valid / cfg_ready): writes points_in_use, always
// ready; write it only while no query is in progress.
// A query walks the table through the single read port of the breakpoint
// memory, one entry per cycle, then runs one 32x32 multiply and a restoring
// divider that retires one quotient bit per cycle; a query outside the table
// skips the scan, the multiply and the divider.
// While the receiver stalls, the block still takes writes and starts the
// next query; that query waits in its final step until the output register
// frees up.
// Reset clears the sequencer and sets points_in_use to 2. The breakpoint
// memory is not cleared; every slot must be written before a query uses it.
module piecewise_linear_table_interp #(
    parameter int MAX_POINTS = pwli_pkg::MAX_POINTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pwli_pkg::CNT_W-1:0]           cfg_data,
    // Input item channel.
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 op,
    input  logic [pwli_pkg::IDX_W-1:0]           entry_index,
    input  logic [pwli_pkg::TIME_W-1:0]          entry_time,
    input  logic signed [pwli_pkg::VAL_W-1:0]    entry_value,
    input  logic [pwli_pkg::TIME_W-1:0]          query_time,
    // Result channel.
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pwli_pkg::VAL_W-1:0]    interp_value,
    output logic [pwli_pkg::IDX_W-1:0]           segment,
    output logic                                 below_range,
    output logic                                 above_range
);
    import pwli_pkg::*;

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int EW = TIME_W + VAL_W;

    // Breakpoint memory: time in the upper half, value in the lower half.
    logic [EW-1:0] mem [MAX_POINTS];
    logic [EW-1:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          wr_en;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]     points_reg, points_next;
    logic [IW-1:0]        last_reg, last_next;
    logic [IW-1:0]        i_reg, i_next;
    logic [TIME_W-1:0]    qt_reg, qt_next;
    logic [TIME_W-1:0]    t0_reg, t0_next;
    logic [TIME_W-1:0]    pt_reg, pt_next;
    logic [VAL_W-1:0]     pv_reg, pv_next;
    logic [VAL_W-1:0]     vlast_reg, vlast_next;
    logic [TIME_W-1:0]    dt_reg, dt_next;
    logic [TIME_W-1:0]    x_reg, x_next;
    logic [TIME_W-1:0]    mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [TIME_W-1:0]    q_reg, q_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0]     res_reg, res_next;
    logic [IW-1:0]        seg_reg, seg_next;
    logic                 below_reg, below_next;
    logic                 above_reg, above_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]     ov_reg, ov_next;
    logic [IDX_W-1:0]     os_reg, os_next;
    logic                 ob_reg, ob_next;
    logic                 oa_reg, oa_next;

    logic                 in_xfer;
    logic [31:0]          n32;
    logic [TIME_W-1:0]    rd_t;
    logic [VAL_W-1:0]     rd_v;
    logic [VAL_W:0]       dv;
    logic [VAL_W:0]       dv_abs;
    logic [TIME_W:0]      trial;
    logic [TIME_W:0]      trial_diff;
    logic                 trial_ge;
    logic [2*TIME_W-1:0]  prod;
    logic [VAL_W+1:0]     sum;

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer = in_valid && !in_stall;
    assign wr_en = in_xfer && (op == OP_WRITE) && (32'(entry_index) < 32'(MAX_POINTS));

    assign rd_t = rd_data_reg[EW-1:VAL_W];
    assign rd_v = rd_data_reg[VAL_W-1:0];

    // Memory read address follows the sequencer step.
    always_comb
    begin
        case (state_reg)
            S_FIRST: rd_addr = last_reg;
            S_LAST:  rd_addr = IW'(1);
            S_SCAN:  rd_addr = IW'(i_reg + IW'(2));
            default: rd_addr = '0;
        endcase
    end

    // Breakpoint memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[IW'(entry_index)] <= {entry_time, entry_value};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Clamp the active point count to the range from 2 to the table depth.
    always_comb
    begin
        n32 = 32'(points_reg);
        if (n32 < 32'd2)
        begin
            n32 = 32'd2;
        end
        if (n32 > 32'(MAX_POINTS))
        begin
            n32 = 32'(MAX_POINTS);
        end
    end

    // Shared arithmetic: segment difference, multiply, divider step, final add.
    always_comb
    begin
        dv = {rd_v[VAL_W-1], rd_v} - {pv_reg[VAL_W-1], pv_reg};
        dv_abs = dv[VAL_W] ? (~dv + 1'b1) : dv;
        prod = {{TIME_W{1'b0}}, mag_reg} * {{TIME_W{1'b0}}, x_reg};
        trial = {rem_reg, q_reg[TIME_W-1]};
        trial_ge = (trial >= {1'b0, dt_reg});
        trial_diff = trial - {1'b0, dt_reg};
        if (neg_reg)
        begin
            sum = {{2{pv_reg[VAL_W-1]}}, pv_reg} - {2'b00, q_reg};
        end
        else
        begin
            sum = {{2{pv_reg[VAL_W-1]}}, pv_reg} + {2'b00, q_reg};
        end
    end

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next = state_reg;
        points_next = points_reg;
        last_next = last_reg;
        i_next = i_reg;
        qt_next = qt_reg;
        t0_next = t0_reg;
        pt_next = pt_reg;
        pv_next = pv_reg;
        vlast_next = vlast_reg;
        dt_next = dt_reg;
        x_next = x_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        seg_next = seg_reg;
        below_next = below_reg;
        above_next = above_reg;
        out_valid_next = out_valid_reg;
        ov_next = ov_reg;
        os_next = os_reg;
        ob_next = ob_reg;
        oa_next = oa_reg;

        if (cfg_valid && cfg_ready)
        begin
            points_next = cfg_data;
        end

        // The receiver took the pending result.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (op == OP_QUERY))
                begin
                    qt_next = query_time;
                    last_next = IW'(n32 - 32'd1);
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                // Entry 0 is on the read port.
                t0_next = rd_t;
                pt_next = rd_t;
                pv_next = rd_v;
                state_next = S_LAST;
            end
            S_LAST:
            begin
                // The last entry in use is on the read port.
                vlast_next = rd_v;
                below_next = 1'b0;
                above_next = 1'b0;
                i_next = '0;
                if (qt_reg < t0_reg)
                begin
                    res_next = pv_reg;
                    seg_next = '0;
                    below_next = 1'b1;
                    state_next = S_FIN;
                end
                else if (qt_reg >= rd_t)
                begin
                    res_next = rd_v;
                    seg_next = last_reg;
                    above_next = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Entry i+1 is on the read port, entry i in the held registers.
                if ((pt_reg <= qt_reg) && (qt_reg < rd_t))
                begin
                    seg_next = i_reg;
                    dt_next = rd_t - pt_reg;
                    x_next = qt_reg - pt_reg;
                    neg_next = dv[VAL_W];
                    mag_next = dv_abs[TIME_W-1:0];
                    state_next = S_MUL;
                end
                else if (IW'(i_reg + IW'(1)) == last_reg)
                begin
                    // No segment brackets the time: times are not increasing.
                    res_next = vlast_reg;
                    seg_next = last_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    pt_next = rd_t;
                    pv_next = rd_v;
                    i_next = IW'(i_reg + IW'(1));
                end
            end
            S_MUL:
            begin
                // The upper product half is already below the divisor.
                rem_next = prod[2*TIME_W-1:TIME_W];
                q_next = prod[TIME_W-1:0];
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // One restoring division step per cycle.
                rem_next = trial_ge ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];
                q_next = {q_reg[TIME_W-2:0], trial_ge};
                cnt_next = DIV_CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                // Apply the quotient to the lower value and saturate.
                if (!sum[VAL_W+1] && (sum[VAL_W:VAL_W-1] != 2'b00))
                begin
                    res_next = {1'b0, {(VAL_W-1){1'b1}}};
                end
                else if (sum[VAL_W+1] && (sum[VAL_W:VAL_W-1] != 2'b11))
                begin
                    res_next = {1'b1, {(VAL_W-1){1'b0}}};
                end
                else
                begin
                    res_next = sum[VAL_W-1:0];
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Load the output register once it is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ov_next = res_reg;
                    os_next = IDX_W'(seg_reg);
                    ob_next = below_reg;
                    oa_next = above_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            points_reg <= POINTS_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
            i_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            points_reg <= points_next;
            out_valid_reg <= out_valid_next;
            cnt_reg <= cnt_next;
            i_reg <= i_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        qt_reg <= qt_next;
        t0_reg <= t0_next;
        pt_reg <= pt_next;
        pv_reg <= pv_next;
        vlast_reg <= vlast_next;
        dt_reg <= dt_next;
        x_reg <= x_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        res_reg <= res_next;
        seg_reg <= seg_next;
        below_reg <= below_next;
        above_reg <= above_next;
        ov_reg <= ov_next;
        os_reg <= os_next;
        ob_reg <= ob_next;
        oa_reg <= oa_next;
    end

    assign out_valid = out_valid_reg;
    assign interp_value = ov_reg;
    assign segment = os_reg;
    assign below_range = ob_reg;
    assign above_range = oa_reg;

`ifndef ASSERT_OFF
    // A stalled result holds until the receiver takes it.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(interp_value) && $stable(segment))
        else $error("result changed while stalled");

    // The sequencer stays one-hot.
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    // The segment scan never runs past the last point in use.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> i_reg < last_reg)
        else $error("scan index past last point");

    // The divider remainder stays below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < dt_reg)
        else $error("divider remainder out of range");

    // The divider hands over after its last step.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && cnt_reg == DIV_CNT_W'(DIV_STEPS - 1) |=> state_reg == S_ADD)
        else $error("divider did not finish");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the piecewise-linear breakpoint table interpolator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwli_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int RANDOM_ITEMS = 1200;
    // Cycle limit for the watchdog on the whole run.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Settling time that lets the engine finish a full-table query.
    localparam int SETTLE_CYCLES = 120;
    localparam int IDLE_PCT = 13;
    localparam int TABLE_DEPTH = MAX_POINTS_DEF;
    localparam int DIRECTED_ROWS = 18;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        seg;
        logic                    below;
        logic                    above;
    } interp_result_t;

    typedef struct {
        op_t                     op;
        logic [IDX_W-1:0]        idx;
        logic [TIME_W-1:0]       etime;
        logic signed [VAL_W-1:0] evalue;
        logic [TIME_W-1:0]       qtime;
    } table_item_t;

    typedef struct {
        table_item_t    item;
        bit             typed;
        interp_result_t result;
    } directed_row_t;

    // Clock, reset and DUT ports.
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CNT_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    op = 1'b0;
    logic [IDX_W-1:0]        entry_index = '0;
    logic [TIME_W-1:0]       entry_time = '0;
    logic signed [VAL_W-1:0] entry_value = '0;
    logic [TIME_W-1:0]       query_time = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [VAL_W-1:0] interp_value;
    logic [IDX_W-1:0]        segment;
    logic                    below_range;
    logic                    above_range;

    // Shadow copy of the breakpoint table and the point count.
    logic [TIME_W-1:0]       bp_time [TABLE_DEPTH];
    logic signed [VAL_W-1:0] bp_value [TABLE_DEPTH];
    logic [CNT_W-1:0]        points_cfg = POINTS_RESET;

    interp_result_t pending_results [$];
    int  errors = 0;
    int  results_seen = 0;
    int  queries_sent = 0;
    int  writes_sent = 0;
    int  random_items = 0;
    int  phases_run = 0;
    int  cycles = 0;
    bit  steady = 1'b0;

    // Directed rows: extremes of time and value, below, above, on a breakpoint,
    // equal breakpoint times, and the top slot index.
    directed_row_t directed [DIRECTED_ROWS] = '{
        '{'{OP_WRITE, 6'd0,  32'h0001_0000, 32'sh8000_0000, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 6'd1,  32'h0003_0000, 32'sh7FFF_FFFF, 32'h0}, 1'b0, '0},
        '{'{OP_QUERY, 6'd0,  32'h0, 32'sh0, 32'h0000_0000}, 1'b1,
          '{32'sh8000_0000, 6'd0, 1'b1, 1'b0}},
        '{'{OP_QUERY, 6'd0,  32'h0, 32'sh0, 32'h0001_0000}, 1'b1,
          '{32'sh8000_0000, 6'd0, 1'b0, 1'b0}},
        '{'{OP_QUERY, 6'd0,  32'h0, 32'sh0, 32'h0002_0000}, 1'b0, '0},
        '{'{OP_QUERY, 6'd0,  32'h0, 32'sh0, 32'h0002_FFFF}, 1'b0, '0},
        '{'{OP_QUERY, 6'd0,  32'h0, 32'sh0, 32'h0003_0000}, 1'b1,
          '{32'sh7FFF_FFFF, 6'd1, 1'b0, 1'b1}},
        '{'{OP_QUERY, 6'd0,  32'h0, 32'sh0, 32'hFFFF_FFFF}, 1'b1,
          '{32'sh7FFF_FFFF, 6'd1, 1'b0, 1'b1}},
        '{'{OP_WRITE, 6'd0,  32'h0000_0000, 32'sh7FFF_FFFF, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 6'd1,  32'hFFFF_FFFF, 32'sh8000_0000, 32'h0}, 1'b0, '0},
        '{'{OP_QUERY, 6'd0,  32'h0, 32'sh0, 32'h0000_0000}, 1'b1,
          '{32'sh7FFF_FFFF, 6'd0, 1'b0, 1'b0}},
        '{'{OP_QUERY, 6'd0,  32'h0, 32'sh0, 32'hFFFF_FFFE}, 1'b0, '0},
        '{'{OP_QUERY, 6'd0,  32'h0, 32'sh0, 32'hFFFF_FFFF}, 1'b1,
          '{32'sh8000_0000, 6'd1, 1'b0, 1'b1}},
        '{'{OP_WRITE, 6'd0,  32'h0000_0010, 32'sh1234_5678, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 6'd1,  32'h0000_0010, 32'shFEDC_BA98, 32'h0}, 1'b0, '0},
        '{'{OP_QUERY, 6'd0,  32'h0, 32'sh0, 32'h0000_0010}, 1'b1,
          '{32'shFEDC_BA98, 6'd1, 1'b0, 1'b1}},
        '{'{OP_QUERY, 6'd0,  32'h0, 32'sh0, 32'h0000_000F}, 1'b1,
          '{32'sh1234_5678, 6'd0, 1'b1, 1'b0}},
        '{'{OP_WRITE, 6'd63, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'h0}, 1'b0, '0}
    };

    piecewise_linear_table_interp i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .entry_index  (entry_index),
        .entry_time   (entry_time),
        .entry_value  (entry_value),
        .query_time   (query_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .interp_value (interp_value),
        .segment      (segment),
        .below_range  (below_range),
        .above_range  (above_range)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Number of breakpoints that take part, after clamping the register.
    function automatic int active_points();
        if (points_cfg < CNT_W'(2))
            return 2;
        if (points_cfg > CNT_W'(TABLE_DEPTH))
            return TABLE_DEPTH;
        return int'(points_cfg);
    endfunction

    // Interpolated value at time t over the shadow table, saturated to 32 bits.
    function automatic interp_result_t interpolate(input logic [TIME_W-1:0] t);
        interp_result_t r;
        int             last;
        int             i;
        bit             found;
        longint         v0;
        longint         dv;
        longint         acc;
        logic [63:0]    mag;
        logic [63:0]    x;
        logic [63:0]    dt;
        logic [63:0]    q;
        r = '0;
        last = active_points() - 1;
        found = 1'b0;
        if (t < bp_time[0])
        begin
            acc = longint'(bp_value[0]);
            r.below = 1'b1;
        end
        else if (t >= bp_time[last])
        begin
            acc = longint'(bp_value[last]);
            r.seg = IDX_W'(last);
            r.above = 1'b1;
        end
        else
        begin
            // No matching segment leaves the last value with both flags clear.
            acc = longint'(bp_value[last]);
            r.seg = IDX_W'(last);
            for (i = 0; i < last; i++)
            begin
                if (!found && bp_time[i] <= t && t < bp_time[i+1])
                begin
                    v0 = longint'(bp_value[i]);
                    dv = longint'(bp_value[i+1]) - v0;
                    mag = (dv < 0) ? -dv : dv;
                    x = 64'(t - bp_time[i]);
                    dt = 64'(bp_time[i+1] - bp_time[i]);
                    q = (mag * x) / dt;
                    acc = (dv < 0) ? v0 - longint'(q) : v0 + longint'(q);
                    r.seg = IDX_W'(i);
                    found = 1'b1;
                end
            end
        end
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        r.value = acc[VAL_W-1:0];
        return r;
    endfunction

    // Breakpoint value, with the extremes showing up often.
    function automatic logic signed [VAL_W-1:0] value_word();
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Query time: mostly inside a segment, sometimes on, below or past the table.
    function automatic logic [TIME_W-1:0] query_point(input int n);
        int                s;
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        s = int'($urandom_range(n - 2));
        lo = bp_time[s];
        hi = bp_time[s+1];
        case ($urandom_range(9))
            0: return lo;
            1: return (bp_time[0] == '0) ? '0 : $urandom_range(bp_time[0] - 1);
            2: return $urandom_range(32'hFFFF_FFFF, bp_time[n-1]);
            3: return $urandom;
            default: return (hi > lo) ? lo + $urandom_range(hi - lo - 1) : lo;
        endcase
    endfunction

    // Drive one item from a falling edge and hold it until the transfer.
    task automatic send_item(input table_item_t it, input bit typed,
                             input interp_result_t typed_result);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= it.op;
        if (it.op == OP_WRITE)
        begin
            entry_index <= it.idx;
            entry_time <= it.etime;
            entry_value <= it.evalue;
            query_time <= $urandom;
        end
        else
        begin
            entry_index <= IDX_W'($urandom);
            entry_time <= $urandom;
            entry_value <= $urandom;
            query_time <= it.qtime;
        end
        do
            @(posedge clk);
        while (in_stall);
        // The transfer happened; update the shadow table or queue the answer.
        if (it.op == OP_WRITE)
        begin
            bp_time[it.idx] = it.etime;
            bp_value[it.idx] = it.evalue;
            writes_sent++;
        end
        else
        begin
            pending_results.push_back(typed ? typed_result : interpolate(it.qtime));
            queries_sent++;
        end
        @(negedge clk);
    endtask

    // Write the point count once the engine has gone idle.
    task automatic write_points(input logic [CNT_W-1:0] count);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= count;
        do
            @(posedge clk);
        while (!cfg_ready);
        points_cfg = count;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One table setting: load the active slots, then a burst of queries
    // with a few rewrites mixed in.
    task automatic run_phase(input logic [CNT_W-1:0] count);
        table_item_t    it;
        interp_result_t none;
        int             n;
        int             nq;
        int             k;
        longint         t_acc;
        longint         step_max;
        bit             shuffled;
        none = '0;
        write_points(count);
        n = active_points();
        shuffled = ($urandom_range(9) == 0);
        case ($urandom_range(2))
            0:
            begin
                t_acc = longint'($urandom_range(32'hF000_0000));
                step_max = 16;
            end
            1:
            begin
                t_acc = longint'($urandom_range(32'hF000_0000));
                step_max = 65536;
            end
            default:
            begin
                t_acc = longint'($urandom_range(65535));
                step_max = (64'sd4294967295 - t_acc) / n;
            end
        endcase
        for (k = 0; k < n; k++)
        begin
            it.op = OP_WRITE;
            it.idx = IDX_W'(k);
            it.etime = shuffled ? TIME_W'($urandom) : t_acc[TIME_W-1:0];
            it.evalue = value_word();
            it.qtime = '0;
            send_item(it, 1'b0, none);
            random_items++;
            t_acc += longint'($urandom_range(32'(step_max), 1));
        end
        nq = int'($urandom_range(50, 20));
        for (k = 0; k < nq; k++)
        begin
            steady = (random_items >= 300 && random_items < 450);
            if ($urandom_range(9) == 0)
            begin
                // Rewrite a slot; an active slot usually keeps its time.
                it.op = OP_WRITE;
                it.idx = IDX_W'($urandom);
                it.etime = (it.idx >= n || $urandom_range(3) == 0) ?
                           TIME_W'($urandom) : bp_time[it.idx];
                it.evalue = value_word();
            end
            else
            begin
                it.op = OP_QUERY;
                it.qtime = query_point(n);
            end
            send_item(it, 1'b0, none);
            random_items++;
        end
        steady = 1'b0;
        phases_run++;
    endtask

    // Stimulus: reset, directed rows, then random table settings.
    initial
    begin : stimulus
        logic [CNT_W-1:0] corner_counts [7];
        logic [CNT_W-1:0] count;
        corner_counts = '{7'd2, 7'd64, 7'd0, 7'd1, 7'd65, 7'd127, 7'd3};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed, directed[i].result);
        while (random_items < RANDOM_ITEMS)
        begin
            if (phases_run < 7)
                count = corner_counts[phases_run];
            else if ($urandom_range(9) == 0)
                count = CNT_W'($urandom_range(127));
            else if ($urandom_range(9) == 0)
                count = CNT_W'($urandom_range(64, 33));
            else
                count = CNT_W'($urandom_range(12, 2));
            run_phase(count);
        end
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Ran %0d breakpoint writes and %0d queries over %0d table settings,",
                 writes_sent, queries_sent, phases_run);
        $display("point counts 0 to 127 included; %0d results checked.", results_seen);
        if (errors == 0)
            $display("[piecewise_linear_table_interp] OK");
        else
            $display("[piecewise_linear_table_interp] ERROR");
        $finish;
    end

    // Receiver back-pressure, changed at the falling edge.
    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);

    // Compare each result transfer with the oldest expected answer.
    always @(posedge clk)
    begin : result_check
        interp_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected none, got value %0d segment %0d",
                         $time, interp_value, segment);
            end
            else
            begin
                want = pending_results.pop_front();
                if (interp_value !== want.value)
                begin
                    errors++;
                    $display("%0t ns: interp_value expected %0d got %0d",
                             $time, want.value, interp_value);
                end
                if (segment !== want.seg)
                begin
                    errors++;
                    $display("%0t ns: segment expected %0d got %0d", $time, want.seg, segment);
                end
                if (below_range !== want.below)
                begin
                    errors++;
                    $display("%0t ns: below_range expected %0b got %0b",
                             $time, want.below, below_range);
                end
                if (above_range !== want.above)
                begin
                    errors++;
                    $display("%0t ns: above_range expected %0b got %0b",
                             $time, want.above, above_range);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, pending_results.size());
            $display("[piecewise_linear_table_interp] ERROR");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
rtl/core/pwli_pkg.sv
rtl/core/piecewise_linear_table_interp.sv
tb/tb.sv
